@@ rtl/core/gssr_pkg.sv @@
// shared types and constants for the six-button pad select scan reader
`default_nettype none

package gssr_pkg;

    // field widths
    localparam int unsigned PinsW     = 6;
    localparam int unsigned BaseW     = 8;
    localparam int unsigned ExtraW    = 5;
    localparam int unsigned ButtonW   = BaseW + ExtraW;
    localparam int unsigned DelayW    = 8;
    localparam int unsigned SettleW   = 16;
    localparam int unsigned InDataW   = 8;
    localparam int unsigned OutDataW  = 24;
    localparam int unsigned ApbAddrW  = 3;
    localparam int unsigned ApbDataW  = 32;

    // register reset values
    localparam logic [DelayW-1:0]  DelayReset  = 8'd14;
    localparam logic [SettleW-1:0] SettleReset = 16'd2000;

    // register word index (paddr[2])
    localparam logic RegPhaseDelay = 1'b0;
    localparam logic RegSettle     = 1'b1;

    // scan sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_LOW1   = 4'd1,
        PH_HIGH1  = 4'd2,
        PH_LOW2   = 4'd3,
        PH_HIGH2  = 4'd4,
        PH_LOW3   = 4'd5,
        PH_HIGH3  = 4'd6,
        PH_LOW4   = 4'd7,
        PH_SETTLE = 4'd8
    } t_phase;

    // configuration values handed to the sequencer
    typedef struct packed {
        logic [DelayW-1:0]  phase_delay;
        logic [SettleW-1:0] settle;
    } t_cfg;

    // one result beat
    typedef struct packed {
        logic               busy_res;
        logic               six_button_pad;
        logic [ButtonW-1:0] button_word;
        logic               read_done;
        logic               select_level;
    } t_scan_res;

endpackage

`default_nettype wire

@@ rtl/core/gssr_cfg.sv @@
// configuration register file with apb-style access
`default_nettype none

module gssr_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gssr_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [gssr_pkg::ApbDataW-1:0]   pwdata,
    output logic      [gssr_pkg::ApbDataW-1:0]   prdata,
    output logic                                 pready,
    output gssr_pkg::t_cfg                       o_cfg
);
    import gssr_pkg::*;

    logic [DelayW-1:0]  r_delay;
    logic [SettleW-1:0] r_settle;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register writes, word select only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DelayReset;
            r_settle <= SettleReset;
        end else if (wr_en) begin
            unique case (reg_sel)
                RegPhaseDelay: r_delay  <= pwdata[DelayW-1:0];
                RegSettle:     r_settle <= pwdata[SettleW-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_sel)
            RegPhaseDelay: prdata = {{(ApbDataW-DelayW){1'b0}}, r_delay};
            RegSettle:     prdata = {{(ApbDataW-SettleW){1'b0}}, r_settle};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.phase_delay = r_delay;
    assign o_cfg.settle      = r_settle;

endmodule

`default_nettype wire

@@ rtl/core/gssr_scan.sv @@
// select sequencer: phase state, wait counter and button capture per tick
`default_nettype none

module gssr_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_start,
    input  wire logic [gssr_pkg::PinsW-1:0]    i_pins,
    input  gssr_pkg::t_cfg                     i_cfg,
    output gssr_pkg::t_scan_res                o_res
);
    import gssr_pkg::*;

    t_phase             r_phase, n_phase;
    logic [SettleW-1:0] r_wait, n_wait;
    logic [BaseW-1:0]   r_base, n_base;
    logic [ExtraW-1:0]  r_extra, n_extra;
    logic               r_six, n_six;
    logic               r_sel, n_sel;

    logic [PinsW-1:0]   pressed;
    logic               elapsed;
    logic [SettleW-1:0] wait_dec;
    logic [SettleW-1:0] delay_ld;
    logic               done;

    // state registers, advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wait  <= '0;
            r_base  <= '0;
            r_extra <= '0;
            r_six   <= 1'b0;
            r_sel   <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_base  <= n_base;
            r_extra <= n_extra;
            r_six   <= n_six;
            r_sel   <= n_sel;
        end
    end

    // pins are active low
    assign pressed  = ~i_pins;
    assign elapsed  = (r_wait <= SettleW'(1));
    assign wait_dec = elapsed ? '0 : r_wait - SettleW'(1);
    assign delay_ld = {{(SettleW-DelayW){1'b0}}, i_cfg.phase_delay};

    // next state and result
    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_base  = r_base;
        n_extra = r_extra;
        n_six   = r_six;
        n_sel   = r_sel;
        done    = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_six   = 1'b0;
                    n_extra = '0;
                    n_base  = {{(BaseW-PinsW){1'b0}}, pressed};
                    n_sel   = 1'b0;
                    n_wait  = delay_ld;
                    n_phase = PH_LOW1;
                end
            end
            PH_LOW1: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    // left and right both low means a pad is answering
                    if (pressed[3:2] != 2'b11) begin
                        n_sel   = 1'b1;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_base[6] = r_base[6] | pressed[4];
                        n_base[7] = r_base[7] | pressed[5];
                        n_sel     = 1'b1;
                        n_wait    = delay_ld;
                        n_phase   = PH_HIGH1;
                    end
                end
            end
            PH_HIGH1: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    n_sel   = 1'b0;
                    n_wait  = delay_ld;
                    n_phase = PH_LOW2;
                end
            end
            PH_LOW2: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    n_sel   = 1'b1;
                    n_wait  = delay_ld;
                    n_phase = PH_HIGH2;
                end
            end
            PH_HIGH2: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    n_sel   = 1'b0;
                    n_wait  = delay_ld;
                    n_phase = PH_LOW3;
                end
            end
            PH_LOW3: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    // all four directions low marks a six-button pad
                    if (pressed[3:0] == 4'hF) begin
                        n_sel   = 1'b1;
                        n_wait  = delay_ld;
                        n_phase = PH_HIGH3;
                    end else begin
                        n_sel   = 1'b1;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
            end
            PH_HIGH3: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    n_extra = {1'b0, pressed[3:0]};
                    n_sel   = 1'b0;
                    n_wait  = delay_ld;
                    n_phase = PH_LOW4;
                end
            end
            PH_LOW4: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    n_extra[4] = r_extra[4] | pressed[0];
                    n_sel      = 1'b1;
                    n_six      = 1'b1;
                    done       = 1'b1;
                    n_wait     = i_cfg.settle;
                    n_phase    = (i_cfg.settle == '0) ? PH_IDLE : PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                n_wait = wait_dec;
                if (elapsed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                // unused phase code recovers to idle
                n_sel   = 1'b1;
                n_wait  = '0;
                n_phase = PH_IDLE;
            end
        endcase

        o_res.select_level   = n_sel;
        o_res.read_done      = done;
        o_res.button_word    = done ? {n_extra, n_base} : '0;
        o_res.six_button_pad = n_six;
        o_res.busy_res       = (n_phase != PH_IDLE);
    end

endmodule

`default_nettype wire

@@ rtl/core/gamepad_select_scan_reader.sv @@
// Six-button pad select scan reader: one input beat per time tick, one result beat per tick.
// Path from input beat accept to result beat: input register, then result register.
// Throughput: 1 beat per cycle while the result side does not stall; the sequencer state updates once per tick.
// Backpressure on the result side stalls the input side one register later.
// Reset (i_rst_n low, synchronous): idle, select high, counters and buttons cleared,
// registers back to phase delay 14 and settle 2000 ticks.
`default_nettype none

module gamepad_select_scan_reader (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input beat
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [0] start_read, [6:1] pad_pins, [7] zero
    input  wire logic [gssr_pkg::InDataW-1:0]     i_s_tdata,
    // result beat
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [0] select_level, [1] read_done, [14:2] button_word, [15] six_button_pad,
    // [16] busy_res, [23:17] zero
    output logic      [gssr_pkg::OutDataW-1:0]    o_m_tdata,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gssr_pkg::ApbAddrW-1:0]    paddr,
    input  wire logic [gssr_pkg::ApbDataW-1:0]    pwdata,
    output logic      [gssr_pkg::ApbDataW-1:0]    prdata,
    output logic                                  pready
);
    import gssr_pkg::*;

    localparam int unsigned ResW = $bits(t_scan_res);

    t_cfg              cfg;
    t_scan_res         res;

    logic              r_in_valid;
    logic              r_in_start;
    logic [PinsW-1:0]  r_in_pins;
    logic              r_out_valid;
    t_scan_res         r_out;
    logic              advance;
    logic              step;

    gssr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake control
    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_start <= i_s_tdata[0];
            r_in_pins  <= i_s_tdata[PinsW:1];
        end
    end

    gssr_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_start (r_in_start),
        .i_pins  (r_in_pins),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutDataW-ResW){1'b0}}, r_out};

endmodule

`default_nettype wire

@@ tb/sv/gssr_scan_checker.sv @@
// checker for the pad scan reader: follows ticks and register writes, predicts and compares results
`timescale 1ns / 1ps

module gssr_scan_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tick beats
    input  wire logic                          i_s_tvalid,
    input  wire logic                          i_s_tready,
    // [0] start_read, [6:1] pad_pins, [7] zero
    input  wire logic [gssr_pkg::InDataW-1:0]  i_s_tdata,
    // result beats
    input  wire logic                          i_m_tvalid,
    input  wire logic                          i_m_tready,
    // [0] select_level, [1] read_done, [14:2] button_word, [15] six_button_pad,
    // [16] busy_res, [23:17] zero
    input  wire logic [gssr_pkg::OutDataW-1:0] i_m_tdata,
    // configuration bus
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [gssr_pkg::ApbAddrW-1:0] paddr,
    input  wire logic [gssr_pkg::ApbDataW-1:0] pwdata,
    // status for the stimulus side
    output int                                 o_fail_count,
    output int                                 o_pending,
    output logic                               o_scan_active
);
    import gssr_pkg::*;

    // register copies
    logic [DelayW-1:0]  cfg_delay;
    logic [SettleW-1:0] cfg_settle;

    // sequencer copy
    t_phase             scan_ph;
    logic [SettleW-1:0] wait_cnt;
    logic [BaseW-1:0]   base_btn;
    logic [ExtraW-1:0]  extra_btn;
    logic               six_flag;
    logic               sel_level;

    t_scan_res          tick_results_q[$];
    int                 beat_idx;
    int                 mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    task automatic report_mismatch(input string what, input int beat, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at result beat %0d: %s got 0x%0h expected 0x%0h",
                 beat, what, got, want);
        mismatch_total++;
    endtask

    // counts down the wait after a select edge, true on the tick it runs out
    function automatic logic wait_done();
        if (wait_cnt <= 16'd1) begin
            wait_cnt = '0;
            return 1'b1;
        end
        wait_cnt = wait_cnt - 16'd1;
        return 1'b0;
    endfunction

    function automatic void select_edge(input logic level, input t_phase nxt_ph);
        sel_level = level;
        wait_cnt  = SettleW'(cfg_delay);
        scan_ph   = nxt_ph;
    endfunction

    // one tick of the scan sequencer
    task automatic advance_scan(input logic start, input logic [PinsW-1:0] pins,
                                output t_scan_res res);
        logic [PinsW-1:0] pressed;
        logic             done;
        pressed = ~pins;
        done    = 1'b0;
        case (scan_ph)
            PH_IDLE: begin
                if (start) begin
                    six_flag  = 1'b0;
                    extra_btn = '0;
                    base_btn  = BaseW'(pressed);
                    select_edge(1'b0, PH_LOW1);
                end
            end
            PH_LOW1: begin
                if (wait_done()) begin
                    // left and right both low means a pad that multiplexes
                    if (pressed[3:2] != 2'b11) begin
                        sel_level = 1'b1;
                        scan_ph   = PH_IDLE;
                        done      = 1'b1;
                    end else begin
                        base_btn[6] = base_btn[6] | pressed[4];
                        base_btn[7] = base_btn[7] | pressed[5];
                        select_edge(1'b1, PH_HIGH1);
                    end
                end
            end
            PH_HIGH1: if (wait_done()) select_edge(1'b0, PH_LOW2);
            PH_LOW2:  if (wait_done()) select_edge(1'b1, PH_HIGH2);
            PH_HIGH2: if (wait_done()) select_edge(1'b0, PH_LOW3);
            PH_LOW3: begin
                if (wait_done()) begin
                    // all four directions low marks a six-button pad
                    if (pressed[3:0] == 4'hF) begin
                        select_edge(1'b1, PH_HIGH3);
                    end else begin
                        sel_level = 1'b1;
                        scan_ph   = PH_IDLE;
                        done      = 1'b1;
                    end
                end
            end
            PH_HIGH3: begin
                if (wait_done()) begin
                    extra_btn = {1'b0, pressed[3:0]};
                    select_edge(1'b0, PH_LOW4);
                end
            end
            PH_LOW4: begin
                if (wait_done()) begin
                    extra_btn[4] = pressed[0];
                    sel_level    = 1'b1;
                    six_flag     = 1'b1;
                    done         = 1'b1;
                    wait_cnt     = cfg_settle;
                    scan_ph      = (cfg_settle == '0) ? PH_IDLE : PH_SETTLE;
                end
            end
            PH_SETTLE: if (wait_done()) scan_ph = PH_IDLE;
            default: begin
                sel_level = 1'b1;
                wait_cnt  = '0;
                scan_ph   = PH_IDLE;
            end
        endcase
        res.select_level   = sel_level;
        res.read_done      = done;
        res.button_word    = done ? {extra_btn, base_btn} : '0;
        res.six_button_pad = six_flag;
        res.busy_res       = (scan_ph != PH_IDLE);
    endtask

    // follow writes, ticks and result beats at each edge
    always @(posedge i_clk) begin : scan_check
        t_scan_res predicted;
        t_scan_res seen;
        if (!i_rst_n) begin
            cfg_delay  = DelayReset;
            cfg_settle = SettleReset;
            scan_ph    = PH_IDLE;
            wait_cnt   = '0;
            base_btn   = '0;
            extra_btn  = '0;
            six_flag   = 1'b0;
            sel_level  = 1'b1;
            beat_idx   = 0;
            tick_results_q.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    RegPhaseDelay: cfg_delay  = pwdata[DelayW-1:0];
                    RegSettle:     cfg_settle = pwdata[SettleW-1:0];
                    default: ;
                endcase
            end
            // accepted tick beat
            if (i_s_tvalid && i_s_tready) begin
                advance_scan(i_s_tdata[0], i_s_tdata[PinsW:1], predicted);
                tick_results_q.push_back(predicted);
            end
            // accepted result beat
            if (i_m_tvalid && i_m_tready) begin
                seen = t_scan_res'(i_m_tdata[$bits(t_scan_res)-1:0]);
                if (tick_results_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", beat_idx,
                                    i_m_tdata, 0);
                end else begin
                    predicted = tick_results_q.pop_front();
                    if (seen.select_level !== predicted.select_level)
                        report_mismatch("select_level", beat_idx, seen.select_level,
                                        predicted.select_level);
                    if (seen.read_done !== predicted.read_done)
                        report_mismatch("read_done", beat_idx, seen.read_done,
                                        predicted.read_done);
                    if (seen.button_word !== predicted.button_word)
                        report_mismatch("button_word", beat_idx, seen.button_word,
                                        predicted.button_word);
                    if (seen.six_button_pad !== predicted.six_button_pad)
                        report_mismatch("six_button_pad", beat_idx, seen.six_button_pad,
                                        predicted.six_button_pad);
                    if (seen.busy_res !== predicted.busy_res)
                        report_mismatch("busy_res", beat_idx, seen.busy_res,
                                        predicted.busy_res);
                end
                beat_idx++;
            end
        end
        o_pending     <= tick_results_q.size();
        o_scan_active <= (scan_ph != PH_IDLE);
    end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the pad scan reader testbench: clock, reset, tick stimulus, result receiver and verdict
`timescale 1ns / 1ps

module tb_top;
    import gssr_pkg::*;

    // how the simulated pad answers on its pins
    typedef enum {PAD_SIX, PAD_PLAIN, PAD_NOISE} t_pad_kind;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // [0] start_read, [6:1] pad_pins, [7] zero
    logic [InDataW-1:0]  i_s_tdata  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [0] select_level, [1] read_done, [14:2] button_word, [15] six_button_pad,
    // [16] busy_res, [23:17] zero
    logic [OutDataW-1:0] o_m_tdata;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ApbAddrW-1:0] paddr   = '0;
    logic [ApbDataW-1:0] pwdata  = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    int                  sender_idle_pct   = 0;
    int                  receiver_idle_pct = 0;
    t_pad_kind           pad_kind          = PAD_SIX;
    int                  fail_count;
    int                  pending;
    logic                scan_active;
    logic [PinsW:0]      directed_ticks [24];

    always #2 i_clk = ~i_clk;

    gamepad_select_scan_reader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gssr_scan_checker scan_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_scan_active (scan_active)
    );

    // result receiver with random stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    function automatic logic [PinsW-1:0] pins_for_pad(input t_pad_kind kind);
        logic [PinsW-1:0] pins;
        pins = PinsW'($urandom);
        case (kind)
            // directions mostly low so the multiplex tests pass
            PAD_SIX:   if ($urandom_range(9) < 7) pins[3:0] = 4'h0;
            // left and right never both low
            PAD_PLAIN: if (pins[3:2] == 2'b00) pins[2] = 1'b1;
            default: ;
        endcase
        return pins;
    endfunction

    task automatic set_idle_mix(input int sender_pct, input int receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    // one tick beat, with random gaps in front
    task automatic send_tick(input logic start, input logic [PinsW-1:0] pins);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, pins, start};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic run_ticks(input int count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(15) == 0) begin
                pick     = $urandom_range(9);
                pad_kind = (pick < 5) ? PAD_SIX : (pick < 8) ? PAD_PLAIN : PAD_NOISE;
            end
            send_tick($urandom_range(99) < 25, pins_for_pad(pad_kind));
        end
    endtask

    // stop sending and wait until every accepted tick has its result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // idle ticks until no read or settle wait is running and all results are in
    task automatic quiesce();
        send_tick(1'b0, pins_for_pad(pad_kind));
        while (scan_active) send_tick(1'b0, pins_for_pad(pad_kind));
        drain();
    endtask

    task automatic write_reg(input logic idx, input logic [ApbDataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus and verdict
    initial begin
        // {pad_pins, start_read}, run with no phase delay and no settle
        directed_ticks = '{
            // six-button read with every pin low, starts while busy ignored
            {6'h00, 1'b1}, {6'h00, 1'b1}, {6'h00, 1'b1}, {6'h00, 1'b1},
            {6'h00, 1'b1}, {6'h00, 1'b1}, {6'h00, 1'b1}, {6'h00, 1'b1},
            // nothing pressed: plain pad at the left/right test
            {6'h3F, 1'b1}, {6'h3F, 1'b0},
            // passes left/right, fails the four-direction test
            {6'h2A, 1'b1}, {6'h13, 1'b0}, {6'h3F, 1'b0}, {6'h3F, 1'b0},
            {6'h3F, 1'b0}, {6'h08, 1'b0},
            // six-button read with mixed extra buttons and home released
            {6'h15, 1'b1}, {6'h00, 1'b0}, {6'h3F, 1'b0}, {6'h3F, 1'b0},
            {6'h3F, 1'b0}, {6'h30, 1'b0}, {6'h3A, 1'b0}, {6'h3F, 1'b0}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, sender idles some, receiver idles a lot
        set_idle_mix(35, 80);
        run_ticks(40);
        // a read may still be running: zero delay and settle let it end quickly
        drain();
        write_reg(RegPhaseDelay, 32'd0);
        write_reg(RegSettle, 32'd0);
        quiesce();

        // directed part: zero delay acts as one tick, zero settle
        foreach (directed_ticks[k])
            send_tick(directed_ticks[k][0], directed_ticks[k][PinsW:1]);
        run_ticks(30);
        quiesce();

        write_reg(RegPhaseDelay, 32'd1);
        run_ticks(60);
        quiesce();

        // sender idles a lot, receiver some
        set_idle_mix(80, 35);
        write_reg(RegPhaseDelay, 32'd3);
        write_reg(RegSettle, 32'd7);
        run_ticks(60);
        quiesce();

        // longest phase delay, short run
        write_reg(RegPhaseDelay, 32'd255);
        write_reg(RegSettle, 32'd0);
        run_ticks(20);
        // the read still running continues on the shorter delay below
        drain();

        // no idling on either side
        set_idle_mix(0, 0);
        write_reg(RegPhaseDelay, 32'd2);
        write_reg(RegSettle, 32'd1);
        quiesce();
        run_ticks(60);
        quiesce();

        // longest settle: the run ends inside the rest period
        write_reg(RegPhaseDelay, 32'd1);
        write_reg(RegSettle, 32'd65535);
        run_ticks(100);
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending != 0)
            $display("%0d expected result beats never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
